/* hdl/i2cme_pkg.sv */
// Shared types and constants for the I2C master byte engine.
package i2cme_pkg;

  localparam int PhaseW     = 4;
  localparam int BitCountW  = 4;
  localparam int DelayW     = 17;
  localparam int CfgW       = 16;
  localparam int AddrW      = 3;
  localparam int DataW      = 32;

  localparam logic [PhaseW-1:0] PH_IDLE    = 4'd0;
  localparam logic [PhaseW-1:0] PH_ST_A    = 4'd1;
  localparam logic [PhaseW-1:0] PH_ST_B    = 4'd2;
  localparam logic [PhaseW-1:0] PH_SP_A    = 4'd3;
  localparam logic [PhaseW-1:0] PH_SP_B    = 4'd4;
  localparam logic [PhaseW-1:0] PH_SP_C    = 4'd5;
  localparam logic [PhaseW-1:0] PH_WR_BIT  = 4'd6;
  localparam logic [PhaseW-1:0] PH_WR_HIGH = 4'd7;
  localparam logic [PhaseW-1:0] PH_WR_LOW  = 4'd8;
  localparam logic [PhaseW-1:0] PH_AK_REL  = 4'd9;
  localparam logic [PhaseW-1:0] PH_AK_HIGH = 4'd10;
  localparam logic [PhaseW-1:0] PH_AK_POLL = 4'd11;
  localparam logic [PhaseW-1:0] PH_RD_LOW  = 4'd12;
  localparam logic [PhaseW-1:0] PH_RD_HIGH = 4'd13;
  localparam logic [PhaseW-1:0] PH_RA_LOW  = 4'd14;
  localparam logic [PhaseW-1:0] PH_RA_HIGH = 4'd15;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [AddrW-3:0] REG_TICKS = 1'b0;
  localparam logic [AddrW-3:0] REG_LIMIT = 1'b1;

  localparam logic [CfgW-1:0] TICKS_RESET = 16'd72;
  localparam logic [CfgW-1:0] LIMIT_RESET = 16'd250;
  localparam logic [BitCountW-1:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [CfgW-1:0] ticks_per_delay_unit;
    logic [CfgW-1:0] ack_wait_limit;
  } cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0]    phase;
    logic [BitCountW-1:0] bit_count;
    logic [7:0]           shift_byte;
    logic [DelayW-1:0]    delay_count;
    logic [CfgW-1:0]      ack_wait_count;
    logic                 scl;
    logic                 sda;
    logic                 oe;
    logic [7:0]           rd_byte;
    logic                 ack_flag;
    logic                 ack_choice;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:          PH_IDLE,
    bit_count:      '0,
    shift_byte:     '0,
    delay_count:    '0,
    ack_wait_count: '0,
    scl:            1'b1,
    sda:            1'b1,
    oe:             1'b1,
    rd_byte:        '0,
    ack_flag:       1'b0,
    ack_choice:     1'b0
  };

endpackage

/* hdl/i2cme_if.sv */
// Handshake channels for engine ticks and per-tick results.
interface i2cme_tick_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [1:0] opcode;
  logic [7:0] write_data;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, cmd_valid, opcode, write_data, send_ack, sda_in,
                  input ready);
  modport sink (input valid, cmd_valid, opcode, write_data, send_ack, sda_in,
                output ready);
endinterface

interface i2cme_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive_enable;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_missing;

  modport source (output valid, scl_level, sda_level, sda_drive_enable, busy_res,
                  done_res, read_data, ack_missing, input ready);
  modport sink (input valid, scl_level, sda_level, sda_drive_enable, busy_res,
                done_res, read_data, ack_missing, output ready);
endinterface

/* hdl/i2cme_regs.sv */
// APB configuration registers of the I2C master byte engine.
module i2cme_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cme_pkg::AddrW-1:0]   paddr,
  input  logic [i2cme_pkg::DataW-1:0]   pwdata,
  output logic [i2cme_pkg::DataW-1:0]   prdata,
  output logic                          pready,
  output i2cme_pkg::cfg_t               cfg
);

  logic wr_en;
  logic [i2cme_pkg::AddrW-3:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[i2cme_pkg::AddrW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_delay_unit <= i2cme_pkg::TICKS_RESET;
      cfg.ack_wait_limit       <= i2cme_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        i2cme_pkg::REG_TICKS: cfg.ticks_per_delay_unit <= pwdata[i2cme_pkg::CfgW-1:0];
        i2cme_pkg::REG_LIMIT: cfg.ack_wait_limit <= pwdata[i2cme_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      i2cme_pkg::REG_TICKS:
        prdata = {{(i2cme_pkg::DataW-i2cme_pkg::CfgW){1'b0}}, cfg.ticks_per_delay_unit};
      i2cme_pkg::REG_LIMIT:
        prdata = {{(i2cme_pkg::DataW-i2cme_pkg::CfgW){1'b0}}, cfg.ack_wait_limit};
      default:
        prdata = '0;
    endcase
  end

endmodule

/* hdl/i2cme_step.sv */
// Next-state logic for one engine tick: phase sequencing, shifting and ack poll.
module i2cme_step (
  input  i2cme_pkg::state_t cur,
  input  i2cme_pkg::cfg_t   cfg,
  input  logic              cmd_valid,
  input  logic [1:0]        opcode,
  input  logic [7:0]        write_data,
  input  logic              send_ack,
  input  logic              sda_in,
  output i2cme_pkg::state_t nxt,
  output logic              done
);

  logic [i2cme_pkg::DelayW-1:0]    unit_ticks;
  logic [i2cme_pkg::DelayW-1:0]    dc_dec;
  logic [i2cme_pkg::BitCountW-1:0] bc_inc;
  logic [7:0]                      shl;

  function automatic i2cme_pkg::state_t go_to(
    input i2cme_pkg::state_t              s,
    input logic [i2cme_pkg::PhaseW-1:0]   ph,
    input logic                           scl,
    input logic                           sda,
    input logic                           oe,
    input logic [1:0]                     units,
    input logic [i2cme_pkg::DelayW-1:0]   t
  );
    i2cme_pkg::state_t r;
    r       = s;
    r.phase = ph;
    r.scl   = scl;
    r.sda   = oe ? sda : 1'b1;
    r.oe    = oe;
    case (units)
      2'd1:    r.delay_count = t;
      2'd2:    r.delay_count = {t[i2cme_pkg::DelayW-2:0], 1'b0};
      default: r.delay_count = '0;
    endcase
    return r;
  endfunction

  assign unit_ticks = (cfg.ticks_per_delay_unit == '0) ? i2cme_pkg::DelayW'(1)
                    : i2cme_pkg::DelayW'(cfg.ticks_per_delay_unit);
  assign dc_dec = (cur.delay_count != '0) ? cur.delay_count - 1'b1 : '0;
  assign bc_inc = cur.bit_count + 1'b1;
  assign shl    = {cur.shift_byte[6:0], 1'b0};

  always_comb begin
    nxt  = cur;
    done = 1'b0;
    if (cur.phase == i2cme_pkg::PH_IDLE) begin
      if (cmd_valid) begin
        case (opcode)
          i2cme_pkg::OP_START:
            nxt = go_to(cur, i2cme_pkg::PH_ST_A, 1'b1, 1'b1, 1'b1, 2'd2, unit_ticks);
          i2cme_pkg::OP_STOP:
            nxt = go_to(cur, i2cme_pkg::PH_SP_A, 1'b0, 1'b0, 1'b1, 2'd2, unit_ticks);
          i2cme_pkg::OP_WRITE: begin
            nxt = go_to(cur, i2cme_pkg::PH_WR_BIT, 1'b0, write_data[7], 1'b1, 2'd1,
                        unit_ticks);
            nxt.ack_flag   = 1'b0;
            nxt.shift_byte = write_data;
            nxt.bit_count  = '0;
          end
          default: begin
            nxt = go_to(cur, i2cme_pkg::PH_RD_LOW, 1'b0, 1'b1, 1'b0, 2'd1, unit_ticks);
            nxt.ack_choice = send_ack;
            nxt.shift_byte = '0;
            nxt.bit_count  = '0;
          end
        endcase
      end
    end else if (cur.phase == i2cme_pkg::PH_AK_POLL) begin
      if (!sda_in) begin
        nxt  = go_to(cur, i2cme_pkg::PH_IDLE, 1'b0, 1'b1, 1'b0, 2'd0, unit_ticks);
        done = 1'b1;
      end else if (cur.ack_wait_count >= cfg.ack_wait_limit) begin
        nxt = go_to(cur, i2cme_pkg::PH_SP_A, 1'b0, 1'b0, 1'b1, 2'd2, unit_ticks);
        nxt.ack_flag = 1'b1;
      end else begin
        nxt.ack_wait_count = cur.ack_wait_count + 1'b1;
      end
    end else begin
      nxt.delay_count = dc_dec;
      if (dc_dec == '0) begin
        case (cur.phase)
          i2cme_pkg::PH_ST_A:
            nxt = go_to(cur, i2cme_pkg::PH_ST_B, 1'b1, 1'b0, 1'b1, 2'd2, unit_ticks);
          i2cme_pkg::PH_ST_B: begin
            nxt  = go_to(cur, i2cme_pkg::PH_IDLE, 1'b0, 1'b0, 1'b1, 2'd0, unit_ticks);
            done = 1'b1;
          end
          i2cme_pkg::PH_SP_A:
            nxt = go_to(cur, i2cme_pkg::PH_SP_B, 1'b1, 1'b0, 1'b1, 2'd2, unit_ticks);
          i2cme_pkg::PH_SP_B:
            nxt = go_to(cur, i2cme_pkg::PH_SP_C, 1'b1, 1'b1, 1'b1, 2'd2, unit_ticks);
          i2cme_pkg::PH_SP_C: begin
            nxt  = go_to(cur, i2cme_pkg::PH_IDLE, 1'b1, 1'b1, 1'b1, 2'd0, unit_ticks);
            done = 1'b1;
          end
          i2cme_pkg::PH_WR_BIT:
            nxt = go_to(cur, i2cme_pkg::PH_WR_HIGH, 1'b1, cur.sda, 1'b1, 2'd1, unit_ticks);
          i2cme_pkg::PH_WR_HIGH:
            nxt = go_to(cur, i2cme_pkg::PH_WR_LOW, 1'b0, cur.sda, 1'b1, 2'd1, unit_ticks);
          i2cme_pkg::PH_WR_LOW: begin
            if (bc_inc >= i2cme_pkg::BITS_PER_BYTE)
              nxt = go_to(cur, i2cme_pkg::PH_AK_REL, 1'b0, 1'b1, 1'b0, 2'd1, unit_ticks);
            else
              nxt = go_to(cur, i2cme_pkg::PH_WR_BIT, 1'b0, shl[7], 1'b1, 2'd1, unit_ticks);
            nxt.shift_byte = shl;
            nxt.bit_count  = bc_inc;
          end
          i2cme_pkg::PH_AK_REL:
            nxt = go_to(cur, i2cme_pkg::PH_AK_HIGH, 1'b1, 1'b1, 1'b0, 2'd1, unit_ticks);
          i2cme_pkg::PH_AK_HIGH: begin
            nxt = go_to(cur, i2cme_pkg::PH_AK_POLL, 1'b1, 1'b1, 1'b0, 2'd0, unit_ticks);
            nxt.ack_wait_count = '0;
          end
          i2cme_pkg::PH_RD_LOW:
            nxt = go_to(cur, i2cme_pkg::PH_RD_HIGH, 1'b1, 1'b1, 1'b0, 2'd1, unit_ticks);
          i2cme_pkg::PH_RD_HIGH: begin
            if (bc_inc >= i2cme_pkg::BITS_PER_BYTE)
              nxt = go_to(cur, i2cme_pkg::PH_RA_LOW, 1'b0, ~cur.ack_choice, 1'b1, 2'd2,
                          unit_ticks);
            else
              nxt = go_to(cur, i2cme_pkg::PH_RD_LOW, 1'b0, 1'b1, 1'b0, 2'd1, unit_ticks);
            nxt.shift_byte = {cur.shift_byte[6:0], sda_in};
            nxt.bit_count  = bc_inc;
          end
          i2cme_pkg::PH_RA_LOW:
            nxt = go_to(cur, i2cme_pkg::PH_RA_HIGH, 1'b1, cur.sda, 1'b1, 2'd2, unit_ticks);
          i2cme_pkg::PH_RA_HIGH: begin
            nxt = go_to(cur, i2cme_pkg::PH_IDLE, 1'b0, cur.sda, 1'b1, 2'd0, unit_ticks);
            nxt.rd_byte = cur.shift_byte;
            done = 1'b1;
          end
          default:
            nxt = go_to(cur, i2cme_pkg::PH_IDLE, cur.scl, cur.sda, cur.oe, 2'd0, unit_ticks);
        endcase
      end
    end
  end

endmodule

/* hdl/i2c_master_byte_engine.sv */
// I2C master byte engine top level: engine state, result register and APB port.
// Each transfer on tick is one bus-engine clock tick and yields one transfer on
// result, from the result register, with the SCL/SDA levels, busy, done, read byte and
// the missing-acknowledge flag after that tick. One tick is taken every cycle:
// the phase, bit and delay counters update in a single pass of logic between
// the engine state register and the result register, and tick stalls only
// while a result waits on result.ready. Phase lengths are whole delay units of
// ticks_per_delay_unit ticks (0 acts as 1); the acknowledge poll tolerates
// ack_wait_limit high samples before a stop is issued and ack_missing is set.
module i2c_master_byte_engine (
  input  logic                          clk,
  input  logic                          rst,
  i2cme_tick_if.sink                    tick,
  i2cme_res_if.source                   result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cme_pkg::AddrW-1:0]   paddr,
  input  logic [i2cme_pkg::DataW-1:0]   pwdata,
  output logic [i2cme_pkg::DataW-1:0]   prdata,
  output logic                          pready
);

  i2cme_pkg::cfg_t   cfg;
  i2cme_pkg::state_t state;
  i2cme_pkg::state_t state_next;
  logic              done_next;
  logic              tick_xfer;

  i2cme_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2cme_step u_step (
    .cur        (state),
    .cfg        (cfg),
    .cmd_valid  (tick.cmd_valid),
    .opcode     (tick.opcode),
    .write_data (tick.write_data),
    .send_ack   (tick.send_ack),
    .sda_in     (tick.sda_in),
    .nxt        (state_next),
    .done       (done_next)
  );

  assign tick.ready = ~result.valid | result.ready;
  assign tick_xfer  = tick.valid & tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= i2cme_pkg::STATE_RESET;
      result.valid <= 1'b0;
    end else if (tick_xfer) begin
      state        <= state_next;
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_xfer) begin
      result.scl_level        <= state_next.scl;
      result.sda_level        <= state_next.sda;
      result.sda_drive_enable <= state_next.oe;
      result.busy_res         <= (state_next.phase != i2cme_pkg::PH_IDLE);
      result.done_res         <= done_next;
      result.read_data        <= state_next.rd_byte;
      result.ack_missing      <= state_next.ack_flag;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.done_res |-> !result.busy_res)
    else $error("done reported while still busy");

  a_poll_released: assert property (@(posedge clk) disable iff (rst)
    state.phase == i2cme_pkg::PH_AK_POLL |-> !state.oe && state.scl)
    else $error("SDA driven or SCL low during acknowledge poll");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    state.bit_count <= i2cme_pkg::BITS_PER_BYTE)
    else $error("bit counter beyond one byte");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    tick_xfer && state.phase == i2cme_pkg::PH_IDLE && !tick.cmd_valid
    |=> state.phase == i2cme_pkg::PH_IDLE)
    else $error("engine left idle without a command");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    !tick_xfer |=> $stable(state))
    else $error("engine state moved without a tick transfer");

endmodule

/* tb/i2c_engine_checker.sv */
// Checker for the I2C master byte engine: predicts every result transfer and compares it, and checks APB reads.
`timescale 1ns / 100ps
module i2c_engine_checker (
  input  logic                        clk,
  input  logic                        rst,
  i2cme_tick_if                       tick,
  i2cme_res_if                        result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [i2cme_pkg::AddrW-1:0] paddr,
  input  logic [i2cme_pkg::DataW-1:0] pwdata,
  input  logic [i2cme_pkg::DataW-1:0] prdata,
  input  logic                        pready,
  output int                          fails,
  output int                          pending
);

  typedef logic [i2cme_pkg::DataW-1:0] word_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       oe;
    logic       busy;
    logic       done;
    logic [7:0] rd;
    logic       nack;
  } bus_lines_t;

  bus_lines_t expected_lines[$];

  logic [i2cme_pkg::CfgW-1:0]      unit_cfg;
  logic [i2cme_pkg::CfgW-1:0]      limit_cfg;
  logic [i2cme_pkg::PhaseW-1:0]    ph_q;
  logic [i2cme_pkg::BitCountW-1:0] nbits_q;
  logic [7:0]                      shreg_q;
  logic [7:0]                      rx_byte_q;
  logic [i2cme_pkg::CfgW-1:0]      poll_q;
  int                              hold_q;
  logic                            scl_q, sda_q, oe_q;
  logic                            nack_q, ack_sel_q, done_q;

  task automatic reset_model();
    unit_cfg  = i2cme_pkg::TICKS_RESET;
    limit_cfg = i2cme_pkg::LIMIT_RESET;
    ph_q      = i2cme_pkg::PH_IDLE;
    nbits_q   = '0;
    shreg_q   = '0;
    rx_byte_q = '0;
    poll_q    = '0;
    hold_q    = 0;
    scl_q     = 1'b1;
    sda_q     = 1'b1;
    oe_q      = 1'b1;
    nack_q    = 1'b0;
    ack_sel_q = 1'b0;
    done_q    = 1'b0;
  endtask

  // A zero unit register counts as one tick per unit.
  task automatic enter_phase(input logic [i2cme_pkg::PhaseW-1:0] p, input logic s,
                             input logic d, input logic e, input int units);
    ph_q   = p;
    scl_q  = s;
    sda_q  = e ? d : 1'b1;
    oe_q   = e;
    hold_q = units * ((unit_cfg == '0) ? 1 : int'(unit_cfg));
  endtask

  task automatic end_command(input logic s, input logic d, input logic e);
    enter_phase(i2cme_pkg::PH_IDLE, s, d, e, 0);
    done_q = 1'b1;
  endtask

  task automatic drive_next_bit();
    enter_phase(i2cme_pkg::PH_WR_BIT, 1'b0, shreg_q[7], 1'b1, 1);
  endtask

  task automatic phase_expired(input logic sd);
    case (ph_q)
      i2cme_pkg::PH_ST_A:    enter_phase(i2cme_pkg::PH_ST_B, 1'b1, 1'b0, 1'b1, 2);
      i2cme_pkg::PH_ST_B:    end_command(1'b0, 1'b0, 1'b1);
      i2cme_pkg::PH_SP_A:    enter_phase(i2cme_pkg::PH_SP_B, 1'b1, 1'b0, 1'b1, 2);
      i2cme_pkg::PH_SP_B:    enter_phase(i2cme_pkg::PH_SP_C, 1'b1, 1'b1, 1'b1, 2);
      i2cme_pkg::PH_SP_C:    end_command(1'b1, 1'b1, 1'b1);
      i2cme_pkg::PH_WR_BIT:  enter_phase(i2cme_pkg::PH_WR_HIGH, 1'b1, sda_q, 1'b1, 1);
      i2cme_pkg::PH_WR_HIGH: enter_phase(i2cme_pkg::PH_WR_LOW, 1'b0, sda_q, 1'b1, 1);
      i2cme_pkg::PH_WR_LOW: begin
        shreg_q = shreg_q << 1;
        nbits_q = nbits_q + 1'b1;
        if (nbits_q >= i2cme_pkg::BITS_PER_BYTE)
          enter_phase(i2cme_pkg::PH_AK_REL, 1'b0, 1'b1, 1'b0, 1);
        else drive_next_bit();
      end
      i2cme_pkg::PH_AK_REL:  enter_phase(i2cme_pkg::PH_AK_HIGH, 1'b1, 1'b1, 1'b0, 1);
      i2cme_pkg::PH_AK_HIGH: begin
        poll_q = '0;
        enter_phase(i2cme_pkg::PH_AK_POLL, 1'b1, 1'b1, 1'b0, 0);
      end
      i2cme_pkg::PH_RD_LOW:  enter_phase(i2cme_pkg::PH_RD_HIGH, 1'b1, 1'b1, 1'b0, 1);
      i2cme_pkg::PH_RD_HIGH: begin
        shreg_q = {shreg_q[6:0], sd};
        nbits_q = nbits_q + 1'b1;
        if (nbits_q >= i2cme_pkg::BITS_PER_BYTE)
          enter_phase(i2cme_pkg::PH_RA_LOW, 1'b0, !ack_sel_q, 1'b1, 2);
        else enter_phase(i2cme_pkg::PH_RD_LOW, 1'b0, 1'b1, 1'b0, 1);
      end
      i2cme_pkg::PH_RA_LOW:  enter_phase(i2cme_pkg::PH_RA_HIGH, 1'b1, sda_q, 1'b1, 2);
      i2cme_pkg::PH_RA_HIGH: begin
        rx_byte_q = shreg_q;
        end_command(1'b0, sda_q, 1'b1);
      end
      default:    enter_phase(i2cme_pkg::PH_IDLE, scl_q, sda_q, oe_q, 0);
    endcase
  endtask

  task automatic predict_tick(input logic cv, input logic [1:0] op, input logic [7:0] wd,
                              input logic sa, input logic sd);
    bus_lines_t snap;
    done_q = 1'b0;
    if (ph_q == i2cme_pkg::PH_IDLE) begin
      if (cv) begin
        case (op)
          i2cme_pkg::OP_START: enter_phase(i2cme_pkg::PH_ST_A, 1'b1, 1'b1, 1'b1, 2);
          i2cme_pkg::OP_STOP:  enter_phase(i2cme_pkg::PH_SP_A, 1'b0, 1'b0, 1'b1, 2);
          i2cme_pkg::OP_WRITE: begin
            nack_q  = 1'b0;
            shreg_q = wd;
            nbits_q = '0;
            drive_next_bit();
          end
          i2cme_pkg::OP_READ: begin
            ack_sel_q = sa;
            shreg_q   = '0;
            nbits_q   = '0;
            enter_phase(i2cme_pkg::PH_RD_LOW, 1'b0, 1'b1, 1'b0, 1);
          end
          default: ;
        endcase
      end
    end else if (ph_q == i2cme_pkg::PH_AK_POLL) begin
      if (!sd) begin
        end_command(1'b0, 1'b1, 1'b0);
      end else if (poll_q >= limit_cfg) begin
        nack_q = 1'b1;
        enter_phase(i2cme_pkg::PH_SP_A, 1'b0, 1'b0, 1'b1, 2);
      end else begin
        poll_q = poll_q + 1'b1;
      end
    end else begin
      if (hold_q > 0) hold_q--;
      if (hold_q == 0) phase_expired(sd);
    end
    snap = '{scl: scl_q, sda: sda_q, oe: oe_q, busy: (ph_q != i2cme_pkg::PH_IDLE),
             done: done_q, rd: rx_byte_q, nack: nack_q};
    expected_lines.push_back(snap);
  endtask

  task automatic compare_field(input string name, input word_t want, input word_t got);
    if (got !== want) begin
      fails++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    bus_lines_t want;
    if (rst) begin
      reset_model();
      expected_lines.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[i2cme_pkg::AddrW-1:2])
            i2cme_pkg::REG_TICKS: unit_cfg = pwdata[i2cme_pkg::CfgW-1:0];
            i2cme_pkg::REG_LIMIT: limit_cfg = pwdata[i2cme_pkg::CfgW-1:0];
            default: ;
          endcase
        end else begin
          compare_field("prdata", (paddr[i2cme_pkg::AddrW-1:2] == i2cme_pkg::REG_TICKS)
                                  ? word_t'(unit_cfg) : word_t'(limit_cfg), prdata);
        end
      end
      if (tick.valid && tick.ready)
        predict_tick(tick.cmd_valid, tick.opcode, tick.write_data, tick.send_ack, tick.sda_in);
      if (result.valid && result.ready) begin
        if (expected_lines.size() == 0) begin
          fails++;
          $error("result transfer with no prediction outstanding");
        end else begin
          want = expected_lines.pop_front();
          compare_field("scl_level", word_t'(want.scl), word_t'(result.scl_level));
          compare_field("sda_level", word_t'(want.sda), word_t'(result.sda_level));
          compare_field("sda_drive_enable", word_t'(want.oe),
                        word_t'(result.sda_drive_enable));
          compare_field("busy_res", word_t'(want.busy), word_t'(result.busy_res));
          compare_field("done_res", word_t'(want.done), word_t'(result.done_res));
          compare_field("read_data", word_t'(want.rd), word_t'(result.read_data));
          compare_field("ack_missing", word_t'(want.nack), word_t'(result.ack_missing));
        end
      end
    end
    pending = expected_lines.size();
  end

endmodule

/* tb/i2c_master_byte_engine_test.sv */
// Top of the I2C master byte engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module i2c_master_byte_engine_test;

  localparam int SDA_NOISE     = 0;
  localparam int SDA_HELD_HIGH = 1;
  localparam int SDA_HELD_LOW  = 2;
  localparam int SDA_LATE_LOW  = 3;

  localparam int QUIET_LIMIT     = 2000;
  localparam int ITEM_TARGET     = 560;
  localparam int CMDS_PER_TIMING = 4;
  localparam int TAIL_TICKS      = 24;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel, penable, pwrite, pready;
  logic [i2cme_pkg::AddrW-1:0] paddr;
  logic [i2cme_pkg::DataW-1:0] pwdata, prdata;
  logic                        idling = 1'b0;
  logic                        last_busy = 1'b0;
  int                          ticks_sent = 0;
  int                          results_got = 0;
  int                          quiet = 0;
  int                          cur_unit, cur_limit;
  int                          fails, pending;

  i2cme_tick_if tick ();
  i2cme_res_if  result ();

  i2c_master_byte_engine dut (
    .clk, .rst, .tick(tick), .result(result),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  i2c_engine_checker lines_check (
    .clk, .rst, .tick(tick), .result(result),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fails, .pending
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (result.valid && result.ready) begin
      results_got <= results_got + 1;
      last_busy   <= result.busy_res;
    end
  end

  always @(posedge clk) begin
    if ((tick.valid && tick.ready) || (result.valid && result.ready) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : ready_side
    int gap;
    result.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = idling ? $urandom_range(19, 0) : 0;
      if (gap > 0) begin
        result.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      result.ready = 1'b1;
      do @(posedge clk); while (!result.valid);
      @(negedge clk);
    end
  end

  function automatic logic line_level(input int mode, input int n, input int low_after);
    if (mode == SDA_NOISE) return 1'($urandom);
    if (mode == SDA_HELD_HIGH) return 1'b1;
    if (mode == SDA_HELD_LOW) return 1'b0;
    return n < low_after;
  endfunction

  task automatic send_tick(input logic cv, input logic [1:0] op, input logic [7:0] wd,
                           input logic sa, input logic sd);
    int gap;
    gap = idling ? $urandom_range(19, 0) : 0;
    if (gap > 0) begin
      tick.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick.valid      = 1'b1;
    tick.cmd_valid  = cv;
    tick.opcode     = op;
    tick.write_data = wd;
    tick.send_ack   = sa;
    tick.sda_in     = sd;
    do @(posedge clk); while (!tick.ready);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Issues one command, then keeps the engine ticking until it is idle again and
  // every result transfer is back. Filler ticks now and then carry a stray command.
  task automatic run_command(input logic [1:0] op, input logic [7:0] wd, input logic sa,
                             input int mode, input bit poke);
    int  low_after, n, first_idx;
    bit  settled;
    low_after = $urandom_range(28 * cur_unit + ((cur_limit > 40) ? 40 : cur_limit) + 4, 0);
    first_idx = ticks_sent;
    send_tick(1'b1, op, wd, sa, line_level(mode, 0, low_after));
    n = 0;
    settled = 1'b0;
    while (!settled) begin
      if (results_got > first_idx && !last_busy) begin
        tick.valid = 1'b0;
        while (results_got != ticks_sent) @(negedge clk);
        settled = !last_busy;
      end
      if (!settled) begin
        n++;
        send_tick((poke && n == 1) || ($urandom_range(15, 0) == 0),
                  2'($urandom_range(3, 0)), 8'($urandom), 1'($urandom),
                  line_level(mode, n, low_after));
      end
    end
  endtask

  task automatic apb_access(input logic wr, input logic [i2cme_pkg::AddrW-3:0] idx,
                            input logic [i2cme_pkg::CfgW-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = i2cme_pkg::DataW'(data);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_timing(input logic [i2cme_pkg::CfgW-1:0] ticks_val,
                            input logic [i2cme_pkg::CfgW-1:0] limit_val);
    apb_access(1'b1, i2cme_pkg::REG_TICKS, ticks_val);
    apb_access(1'b1, i2cme_pkg::REG_LIMIT, limit_val);
    apb_access(1'b0, i2cme_pkg::REG_TICKS, '0);
    apb_access(1'b0, i2cme_pkg::REG_LIMIT, '0);
    cur_unit  = (ticks_val == '0) ? 1 : int'(ticks_val);
    cur_limit = int'(limit_val);
  endtask

  initial begin : stimulus
    int k, n, mode, pick;
    tick.valid      = 1'b0;
    tick.cmd_valid  = 1'b0;
    tick.opcode     = i2cme_pkg::OP_START;
    tick.write_data = '0;
    tick.send_ack   = 1'b0;
    tick.sda_in     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    cur_unit  = int'(i2cme_pkg::TICKS_RESET);
    cur_limit = int'(i2cme_pkg::LIMIT_RESET);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset values of both registers
    apb_access(1'b0, i2cme_pkg::REG_TICKS, '0);
    apb_access(1'b0, i2cme_pkg::REG_LIMIT, '0);

    idling = 1'b1;
    set_timing(16'd0, 16'd0);
    run_command(i2cme_pkg::OP_WRITE, 8'hFF, 1'b0, SDA_HELD_HIGH, 1'b0);
    run_command(i2cme_pkg::OP_READ, 8'h00, 1'b1, SDA_NOISE, 1'b0);
    run_command(i2cme_pkg::OP_WRITE, 8'h00, 1'b1, SDA_HELD_LOW, 1'b1);
    run_command(i2cme_pkg::OP_READ, 8'hFF, 1'b0, SDA_HELD_HIGH, 1'b0);
    run_command(i2cme_pkg::OP_READ, 8'h5A, 1'b1, SDA_HELD_LOW, 1'b0);
    run_command(i2cme_pkg::OP_STOP, 8'h00, 1'b0, SDA_NOISE, 1'b1);
    run_command(i2cme_pkg::OP_START, 8'hFF, 1'b1, SDA_NOISE, 1'b1);

    set_timing(16'd2, 16'd1);
    run_command(i2cme_pkg::OP_WRITE, 8'hA5, 1'b0, SDA_NOISE, 1'b1);
    run_command(i2cme_pkg::OP_READ, 8'h3C, 1'b1, SDA_LATE_LOW, 1'b0);
    run_command(i2cme_pkg::OP_WRITE, 8'h96, 1'b0, SDA_LATE_LOW, 1'b0);

    // longest acknowledge limit, streamed without gaps
    idling = 1'b0;
    set_timing(16'd1, 16'hFFFF);
    run_command(i2cme_pkg::OP_WRITE, 8'hC3, 1'b1, SDA_LATE_LOW, 1'b0);

    k = 0;
    while (ticks_sent < ITEM_TARGET) begin
      if (k % CMDS_PER_TIMING == 0)
        set_timing(16'($urandom_range(3, 0)), 16'($urandom_range(40, 0)));
      idling = ($urandom_range(3, 0) != 0);
      pick = $urandom_range(9, 0);
      if (pick < 4)      mode = SDA_NOISE;
      else if (pick < 8) mode = SDA_LATE_LOW;
      else if (pick < 9) mode = SDA_HELD_HIGH;
      else               mode = SDA_HELD_LOW;
      run_command(2'($urandom_range(3, 0)), 8'($urandom), 1'($urandom), mode, 1'b0);
      k++;
    end

    // widest delay unit: the first stop phase outlasts the run
    idling = 1'b0;
    set_timing(16'hFFFF, 16'd250);
    send_tick(1'b1, i2cme_pkg::OP_STOP, 8'h00, 1'b0, 1'b1);
    for (n = 1; n < TAIL_TICKS; n++)
      send_tick(1'($urandom), 2'($urandom_range(3, 0)), 8'($urandom), 1'($urandom),
                1'($urandom));

    tick.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (fails == 0 && pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
